### rtl/core/rfsi_pkg.sv
// rfsi_pkg: shared types, codes and constants of the reach-filtered sorted insert block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rfsi_pkg;

    localparam int ID_W          = 32;
    localparam int DIST_W        = 21;
    localparam int MODE_W        = 2;
    localparam int LIMIT_W       = 16;
    localparam int FACTOR_W      = 7;
    localparam int THRESH_W      = 23;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 16;
    localparam int DEF_TABLE_DEPTH = 64;

    // transport modes
    localparam logic [MODE_W-1:0] MODE_METRO = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BIKE  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FOOT  = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TRANSPORT_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MINUTES_LIMIT  = 2'd1;

    // input kinds
    localparam logic KIND_OFFER = 1'b0;
    localparam logic KIND_DRAIN = 1'b1;

    typedef struct packed {
        logic signed [ID_W-1:0] id;
        logic [DIST_W-1:0]      distance;
    } entry_t;

    typedef struct packed {
        logic insert;
        logic shift;
    } cell_cmd_t;

    // 5 * speed: travel time test is 3*dist <= limit * factor
    function automatic logic [FACTOR_W-1:0] speed_factor(input logic [MODE_W-1:0] mode);
        logic [FACTOR_W-1:0] f;
        case (mode)
            MODE_METRO: f = 7'd100;
            MODE_BIKE:  f = 7'd75;
            MODE_FOOT:  f = 7'd25;
            default:    f = 7'd25;
        endcase
        return f;
    endfunction

endpackage

`default_nettype wire

### rtl/core/reach_filtered_sorted_insert_top.sv
// reach_filtered_sorted_insert_top: travel time filter feeding a sorted shift-insert chain.
// Depends on rfsi_pkg, rfsi_filter and rfsi_cell.
//
// Usage:
//   Input channel s_*: kind 0 offers a candidate (id, distance); kind 1 drains.
//   An offer that passes 3*distance <= 5*limit*speed is placed in sorted
//   order (distance, then signed id, equal keys after stored ones) by the
//   row of compare cells; offers stream one per cycle while s_ready is high.
//   A full table drops the item and sets the overflow flag.
//   A drain holds s_ready low while the chain shifts entries out of cell 0,
//   one transaction per cycle on m_* while m_ready is high; the first result
//   is loaded into the output register once the drain state is entered;
//   an empty table gives one result with table_empty set.
//   A stalled receiver pauses the shifting and keeps s_ready low until the
//   drain ends; offers are taken while the final result of a drain waits.
//   Configuration: cfg_wr_en writes cfg_wdata to register cfg_index
//   (0 transport mode, 1 minutes limit); takes effect for the next item.
//   Reset (aresetn low, synchronous) empties the table, clears overflow,
//   sets foot mode and a zero limit. No clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module reach_filtered_sorted_insert_top import rfsi_pkg::*; #(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic                   s_kind,
    input  wire logic signed [ID_W-1:0] s_item_id,
    input  wire logic [DIST_W-1:0]      s_distance_centikm,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic signed [ID_W-1:0]      m_out_id,
    output logic [DIST_W-1:0]           m_out_distance,
    output logic                        m_last_entry,
    output logic                        m_table_empty,
    output logic                        m_overflowed,
    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wdata
);

    typedef enum logic {
        ST_IDLE,
        ST_DRAIN
    } state_t;

    state_t    state_reg, state_next;
    logic      ovf_reg, ovf_next;
    logic      drain_ovf_reg, drain_ovf_next;
    logic      m_valid_reg, m_valid_next;
    entry_t    m_entry_reg, m_entry_next;
    logic      m_last_reg, m_last_next;
    logic      m_empty_reg, m_empty_next;
    logic      m_ovf_reg, m_ovf_next;

    logic      pass;
    logic      accept;
    logic      out_free;
    logic      table_full;
    cell_cmd_t cmd;
    entry_t    new_entry;

    logic      cell_valid [TABLE_DEPTH];
    entry_t    cell_entry [TABLE_DEPTH];
    logic      cell_goes  [TABLE_DEPTH];

    rfsi_filter u_filter (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .distance  (s_distance_centikm),
        .pass      (pass)
    );

    assign s_ready    = (state_reg == ST_IDLE);
    assign accept     = s_valid && s_ready;
    assign out_free   = !m_valid_reg || m_ready;
    assign table_full = cell_valid[TABLE_DEPTH-1];
    assign new_entry  = '{id: s_item_id, distance: s_distance_centikm};

    always_comb begin
        cmd.insert = accept && (s_kind == KIND_OFFER) && pass && !table_full;
        cmd.shift  = (state_reg == ST_DRAIN) && out_free && cell_valid[0];
    end

    genvar g;
    generate
        for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
            logic   l_valid, l_goes, r_valid;
            entry_t l_entry, r_entry;
            if (g == 0) begin : g_first
                assign l_valid = 1'b0;
                assign l_goes  = 1'b0;
                assign l_entry = '0;
            end else begin : g_mid
                assign l_valid = cell_valid[g-1];
                assign l_goes  = cell_goes[g-1];
                assign l_entry = cell_entry[g-1];
            end
            if (g == TABLE_DEPTH - 1) begin : g_last
                assign r_valid = 1'b0;
                assign r_entry = '0;
            end else begin : g_inner
                assign r_valid = cell_valid[g+1];
                assign r_entry = cell_entry[g+1];
            end
            rfsi_cell u_cell (
                .aclk           (aclk),
                .aresetn        (aresetn),
                .cmd            (cmd),
                .new_entry      (new_entry),
                .left_valid     (l_valid),
                .left_entry     (l_entry),
                .left_goes_here (l_goes),
                .right_valid    (r_valid),
                .right_entry    (r_entry),
                .valid          (cell_valid[g]),
                .entry          (cell_entry[g]),
                .goes_here      (cell_goes[g])
            );
        end
    endgenerate

    always_comb begin
        state_next     = state_reg;
        ovf_next       = ovf_reg;
        drain_ovf_next = drain_ovf_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_entry_next   = m_entry_reg;
        m_last_next    = m_last_reg;
        m_empty_next   = m_empty_reg;
        m_ovf_next     = m_ovf_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && s_kind == KIND_OFFER && pass && table_full) begin
                    ovf_next = 1'b1;
                end
                if (accept && s_kind == KIND_DRAIN) begin
                    drain_ovf_next = ovf_reg;
                    ovf_next       = 1'b0;
                    state_next     = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    if (cell_valid[0]) begin
                        m_entry_next = cell_entry[0];
                        m_last_next  = !cell_valid[1];
                        m_empty_next = 1'b0;
                        m_ovf_next   = drain_ovf_reg;
                        if (!cell_valid[1]) begin
                            state_next = ST_IDLE;
                        end
                    end else begin
                        m_entry_next = '0;
                        m_last_next  = 1'b0;
                        m_empty_next = 1'b1;
                        m_ovf_next   = 1'b0;
                        state_next   = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            ovf_reg       <= 1'b0;
            drain_ovf_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            ovf_reg       <= ovf_next;
            drain_ovf_reg <= drain_ovf_next;
            m_valid_reg   <= m_valid_next;
        end
        m_entry_reg <= m_entry_next;
        m_last_reg  <= m_last_next;
        m_empty_reg <= m_empty_next;
        m_ovf_reg   <= m_ovf_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_out_id       = m_entry_reg.id;
    assign m_out_distance = m_entry_reg.distance;
    assign m_last_entry   = m_last_reg;
    assign m_table_empty  = m_empty_reg;
    assign m_overflowed   = m_ovf_reg;

endmodule

`default_nettype wire

### rtl/core/rfsi_filter.sv
// rfsi_filter: configuration registers and the registered travel time threshold.
// Depends on rfsi_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rfsi_filter import rfsi_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic [DIST_W-1:0]     distance,
    output logic                       pass
);

    logic [MODE_W-1:0]   mode_reg, mode_next;
    logic [LIMIT_W-1:0]  limit_reg, limit_next;
    logic [THRESH_W-1:0] thresh_reg, thresh_next;
    logic [THRESH_W-1:0] lhs;

    always_comb begin
        mode_next  = mode_reg;
        limit_next = limit_reg;
        if (cfg_wr_en && cfg_index == REG_TRANSPORT_MODE) begin
            mode_next = cfg_wdata[MODE_W-1:0];
        end
        if (cfg_wr_en && cfg_index == REG_MINUTES_LIMIT) begin
            limit_next = cfg_wdata[LIMIT_W-1:0];
        end
        thresh_next = THRESH_W'(limit_next) * THRESH_W'(speed_factor(mode_next));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_FOOT;
            limit_reg  <= '0;
            thresh_reg <= '0;
        end else begin
            mode_reg   <= mode_next;
            limit_reg  <= limit_next;
            thresh_reg <= thresh_next;
        end
    end

    assign lhs  = {1'b0, distance, 1'b0} + THRESH_W'(distance);
    assign pass = (lhs <= thresh_reg);

endmodule

`default_nettype wire

### rtl/core/rfsi_cell.sv
// rfsi_cell: one slot of the sorted chain; compares, inserts and shifts.
// Depends on rfsi_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rfsi_cell import rfsi_pkg::*; (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire cell_cmd_t cmd,
    input  wire entry_t    new_entry,
    input  wire logic      left_valid,
    input  wire entry_t    left_entry,
    input  wire logic      left_goes_here,
    input  wire logic      right_valid,
    input  wire entry_t    right_entry,
    output logic           valid,
    output entry_t         entry,
    output logic           goes_here
);

    logic   valid_reg, valid_next;
    entry_t entry_reg, entry_next;

    // new item belongs at or before this slot
    assign goes_here = !valid_reg
                    || (entry_reg.distance > new_entry.distance)
                    || ((entry_reg.distance == new_entry.distance)
                        && ($signed(entry_reg.id) > $signed(new_entry.id)));

    always_comb begin
        valid_next = valid_reg;
        entry_next = entry_reg;
        if (cmd.shift) begin
            valid_next = right_valid;
            entry_next = right_entry;
        end else if (cmd.insert) begin
            if (left_goes_here) begin
                valid_next = left_valid;
                entry_next = left_entry;
            end else if (goes_here) begin
                valid_next = 1'b1;
                entry_next = new_entry;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        entry_reg <= entry_next;
    end

    assign valid = valid_reg;
    assign entry = entry_reg;

endmodule

`default_nettype wire
